// ===== hw/rtl/tdps_pkg.sv =====
`timescale 1ns / 1ps

package tdps_pkg;

  // Default build of the store and the sample path
  localparam int STORE_DEPTH_DEF = 4096;  // power of two, 256 to 65536
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int PHASE_FRAC_DEF  = 16;

  // Register widths and configuration port
  localparam int RATIO_W    = 16;
  localparam int GRAIN_W    = 12;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PITCH_RATIO  = 1'b0;
  localparam cfg_idx_t REG_GRAIN_LENGTH = 1'b1;

  // Fixed-point constants
  localparam int RATIO_ONE  = 16384;  // unity pitch in Q2.14
  localparam int RATIO_FRAC = 14;
  localparam int WIN_FRAC   = 15;     // window weights are Q1.15
  localparam int GRAIN_MIN  = 64;
  localparam int GRAIN_RST  = 1024;

endpackage

// ===== hw/rtl/tdps_ram.sv =====
`timescale 1ns / 1ps

module tdps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tdps_csu.sv =====
`timescale 1ns / 1ps

// Shared compare-subtract step: subtract b from a when a >= b, else hold a.
module tdps_csu #(
  parameter int WIDTH = 32
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  output logic [WIDTH-1:0] res,
  output logic             ge
);

  logic [WIDTH:0] diff;

  assign diff = {1'b0, a} - {1'b0, b};
  assign ge   = ~diff[WIDTH];
  assign res  = ge ? diff[WIDTH-1:0] : a;

endmodule

// ===== hw/rtl/two_tap_delay_pitch_shifter.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                              | Direction
// ----------+------------------------------------+-----------
// input     | in_valid, in_ready, in_sample_in   | sample in
// output    | out_valid, out_ready, out_sample_out | sample out
// config    | cfg_we, cfg_idx, cfg_data          | register write
//
// An item is taken only while idle and runs to its end before the next one:
// QB compare-subtract steps (QB = 6 at the default store depth) reduce the
// phase modulo the grain, 16 steps divide the window weight, each of the two
// taps takes two RAM reads, a difference and one multiply, and the weighted
// sum follows. All steps share one compare-subtract unit and one multiplier.
// Reset is synchronous, active low; the delay store is not swept, a fill
// mark makes unwritten entries read as zero. A finished sample waits until
// the output register is free; only then is the next input taken.
module two_tap_delay_pitch_shifter #(
  parameter int STORE_DEPTH     = tdps_pkg::STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS     = tdps_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_FRAC_BITS = tdps_pkg::PHASE_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  tdps_pkg::cfg_idx_t                  cfg_idx,
  input  logic [tdps_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_sample_out
);

  localparam int F      = PHASE_FRAC_BITS;
  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int GRAIN_MAXV = (1 << tdps_pkg::GRAIN_W) - 1;
  localparam int GMAX   = (STORE_DEPTH / 2 > GRAIN_MAXV) ? GRAIN_MAXV : STORE_DEPTH / 2;
  localparam int GS_W   = $clog2(GMAX + 1);
  localparam int PH_W   = GS_W + F;
  localparam int QB     = $clog2((GMAX + 3) / tdps_pkg::GRAIN_MIN + 2);
  localparam int U_W    = PH_W + QB;
  localparam int SH_L   = (F >= tdps_pkg::RATIO_FRAC) ? F - tdps_pkg::RATIO_FRAC : 0;
  localparam int SH_R   = (F < tdps_pkg::RATIO_FRAC) ? tdps_pkg::RATIO_FRAC - F : 0;
  localparam int ST_W   = tdps_pkg::RATIO_W + 1 + SH_L;
  localparam int V_W    = ((PH_W > ST_W) ? PH_W : ST_W) + 2;
  localparam int W_W    = tdps_pkg::WIN_FRAC + 1;
  localparam int CNT_W  = $clog2((QB > W_W) ? QB : W_W);
  localparam int POS_W  = AW + F;
  localparam int MA_W   = SB + 1;
  localparam int MB_W   = ((F > W_W) ? F : W_W) + 1;
  localparam int PR_W   = MA_W + MB_W;

  localparam logic [W_W-1:0]         W_ONE    = W_W'(1) << tdps_pkg::WIN_FRAC;
  localparam logic signed [PR_W-1:0] TAP_HALF = PR_W'(1) << (F - 1);
  localparam logic signed [PR_W:0]   OUT_HALF = (PR_W + 1)'(1) << (tdps_pkg::WIN_FRAC - 1);
  localparam logic signed [PR_W:0]   SAT_MAX  = {{(PR_W - SB + 2){1'b0}}, {(SB - 1){1'b1}}};
  localparam logic signed [PR_W:0]   SAT_MIN  = {{(PR_W - SB + 2){1'b1}}, {(SB - 1){1'b0}}};

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SUM  = 4'd1;
  localparam logic [3:0] S_FIX  = 4'd2;
  localparam logic [3:0] S_MOD  = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_RD0  = 4'd6;
  localparam logic [3:0] S_RD1  = 4'd7;
  localparam logic [3:0] S_DIF  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_TAP  = 4'd10;
  localparam logic [3:0] S_OW1  = 4'd11;
  localparam logic [3:0] S_OW2  = 4'd12;
  localparam logic [3:0] S_ACC  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  // Control and configuration state
  logic [3:0]                    state_r, state_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          tap_sel_r, tap_sel_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [tdps_pkg::RATIO_W-1:0]  ratio_r;
  logic [tdps_pkg::GRAIN_W-1:0]  grain_r;
  logic [AW-1:0]                 wi_r;
  logic                          full_r;
  logic [PH_W-1:0]               phase_r;

  // Datapath registers
  logic signed [V_W-1:0]         v_r;
  logic [U_W-1:0]                rem_r;
  logic [W_W-1:0]                quo_r;
  logic [W_W-1:0]                w2_r;
  logic                          half_r;
  logic [PH_W-1:0]               dly_r;
  logic [POS_W-1:0]              pos1_r, pos2_r;
  logic                          rv_r;
  logic signed [SB-1:0]          s0_r;
  logic signed [SB:0]            diff_r;
  logic signed [PR_W-1:0]        prod_r;
  logic signed [SB-1:0]          t1_r, t2_r;
  logic signed [PR_W:0]          acc_r;
  logic signed [SB-1:0]          res_r;
  logic signed [SB-1:0]          out_sample_r;

  // Combinational signals
  logic                          in_fire;
  logic [GS_W-1:0]               gs;
  logic [PH_W-1:0]               g;
  logic signed [tdps_pkg::RATIO_W:0] step_raw;
  logic signed [ST_W-1:0]        step_s;
  logic signed [V_W-1:0]         fix_val;
  logic [PH_W:0]                 twop;
  logic                          h;
  logic [PH_W:0]                 a_win;
  logic [POS_W-1:0]              base;
  logic [POS_W-1:0]              hg;
  logic [POS_W-1:0]              cur_pos;
  logic [AW-1:0]                 i0;
  logic [AW-1:0]                 ram_raddr;
  logic [SB-1:0]                 ram_rdata;
  logic [F-1:0]                  frac;
  logic signed [SB-1:0]          s1;
  logic [U_W-1:0]                csu_a, csu_b, csu_res;
  logic                          csu_ge;
  logic signed [MA_W-1:0]        mul_a;
  logic signed [MB_W-1:0]        mul_b;
  logic signed [PR_W-1:0]        tap_rnd, tap_sh;
  logic signed [SB-1:0]          tap_val;
  logic signed [PR_W:0]          acc_sum, out_sh;
  logic signed [SB-1:0]          sat_val;

  assign in_ready       = (state_r == S_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // Clamp the grain and scale it to phase units
  always_comb begin
    priority if (grain_r < tdps_pkg::GRAIN_W'(tdps_pkg::GRAIN_MIN)) begin
      gs = GS_W'(tdps_pkg::GRAIN_MIN);
    end else if (grain_r > tdps_pkg::GRAIN_W'(GMAX)) begin
      gs = GS_W'(GMAX);
    end else begin
      gs = GS_W'(grain_r);
    end
  end

  assign g = {gs, {F{1'b0}}};

  // Phase step: ratio minus one, moved to the phase fraction
  assign step_raw = $signed({1'b0, ratio_r}) -
                    $signed((tdps_pkg::RATIO_W + 1)'(tdps_pkg::RATIO_ONE));
  assign step_s   = (ST_W'(step_raw) <<< SH_L) >>> SH_R;

  // Fold a negative phase sum back by one grain
  assign fix_val = v_r[V_W-1] ? v_r + V_W'($signed({1'b0, g})) : v_r;

  // Window numerator and half-grain flag
  assign twop  = {phase_r, 1'b0};
  assign h     = twop < {1'b0, g};
  assign a_win = h ? twop : {g, 1'b0} - twop;

  // Tap addressing
  assign base      = {wi_r, {F{1'b0}}};
  assign hg        = POS_W'(g >> 1);
  assign cur_pos   = tap_sel_r ? pos2_r : pos1_r;
  assign i0        = cur_pos[POS_W-1:F];
  assign frac      = cur_pos[F-1:0];
  assign ram_raddr = (state_r == S_RD1) ? i0 + 1'b1 : i0;
  assign s1        = rv_r ? $signed(ram_rdata) : '0;

  tdps_ram #(
    .WIDTH (SB),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (wi_r),
    .wdata (in_sample_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Feed the shared compare-subtract unit
  always_comb begin
    unique case (state_r)
      S_MOD: begin
        csu_a = rem_r;
        csu_b = U_W'(g) << cnt_r;
      end
      S_DIV: begin
        csu_a = (cnt_r == CNT_W'(tdps_pkg::WIN_FRAC)) ? rem_r : rem_r << 1;
        csu_b = U_W'(g);
      end
      default: begin
        csu_a = rem_r;
        csu_b = U_W'(g);
      end
    endcase
  end

  tdps_csu #(
    .WIDTH (U_W)
  ) u_csu (
    .a   (csu_a),
    .b   (csu_b),
    .res (csu_res),
    .ge  (csu_ge)
  );

  // Feed the shared multiplier
  always_comb begin
    unique case (state_r)
      S_MUL: begin
        mul_a = diff_r;
        mul_b = MB_W'($signed({1'b0, frac}));
      end
      S_OW2: begin
        mul_a = MA_W'(t2_r);
        mul_b = MB_W'($signed({1'b0, w2_r}));
      end
      default: begin
        mul_a = MA_W'(t1_r);
        mul_b = MB_W'($signed({1'b0, quo_r}));
      end
    endcase
  end

  // Round the interpolated tap
  assign tap_rnd = prod_r + TAP_HALF;
  assign tap_sh  = tap_rnd >>> F;
  assign tap_val = s0_r + SB'(tap_sh);

  // Sum weighted taps, round and saturate
  assign acc_sum = acc_r + (PR_W + 1)'(prod_r) + OUT_HALF;
  assign out_sh  = acc_sum >>> tdps_pkg::WIN_FRAC;

  always_comb begin
    priority if (out_sh > SAT_MAX) begin
      sat_val = SAT_MAX[SB-1:0];
    end else if (out_sh < SAT_MIN) begin
      sat_val = SAT_MIN[SB-1:0];
    end else begin
      sat_val = out_sh[SB-1:0];
    end
  end

  // Sequence one transaction through the steps
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    tap_sel_nxt = tap_sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SUM;
      end
      S_SUM:  state_nxt = S_FIX;
      S_FIX: begin
        cnt_nxt   = CNT_W'(QB - 1);
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (cnt_r == '0) begin
          state_nxt = S_PREP;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_PREP: begin
        cnt_nxt     = CNT_W'(tdps_pkg::WIN_FRAC);
        tap_sel_nxt = 1'b0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_RD0;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_RD0:  state_nxt = S_RD1;
      S_RD1:  state_nxt = S_DIF;
      S_DIF:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_TAP;
      S_TAP: begin
        if (!tap_sel_r) begin
          tap_sel_nxt = 1'b1;
          state_nxt   = S_RD0;
        end else begin
          state_nxt = S_OW1;
        end
      end
      S_OW1:  state_nxt = S_OW2;
      S_OW2:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) out_valid_nxt = 1'b1;
  end

  // Control, configuration and phase registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      tap_sel_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ratio_r     <= tdps_pkg::RATIO_W'(tdps_pkg::RATIO_ONE);
      grain_r     <= tdps_pkg::GRAIN_W'(tdps_pkg::GRAIN_RST);
      wi_r        <= '0;
      full_r      <= 1'b0;
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      tap_sel_r   <= tap_sel_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          tdps_pkg::REG_PITCH_RATIO:  ratio_r <= cfg_data[tdps_pkg::RATIO_W-1:0];
          tdps_pkg::REG_GRAIN_LENGTH: grain_r <= cfg_data[tdps_pkg::GRAIN_W-1:0];
        endcase
      end
      if (in_fire) begin
        wi_r <= wi_r + 1'b1;
        if (wi_r == AW'(STORE_DEPTH - 1)) full_r <= 1'b1;
      end
      if ((state_r == S_MOD) && (cnt_r == '0)) begin
        phase_r <= csu_res[PH_W-1:0];
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    rv_r   <= full_r || (ram_raddr < wi_r);
    unique case (state_r)
      S_SUM: begin
        v_r <= V_W'($signed({1'b0, phase_r})) + V_W'(step_s);
      end
      S_FIX: begin
        rem_r <= U_W'($unsigned(fix_val));
      end
      S_MOD: begin
        rem_r <= csu_res;
      end
      S_PREP: begin
        rem_r  <= U_W'(a_win);
        half_r <= h;
        dly_r  <= g - phase_r;
      end
      S_DIV: begin
        rem_r <= csu_res;
        quo_r <= {quo_r[W_W-2:0], csu_ge};
        if (cnt_r == CNT_W'(tdps_pkg::WIN_FRAC)) begin
          pos1_r <= base - POS_W'(dly_r);
        end
        if (cnt_r == CNT_W'(tdps_pkg::WIN_FRAC - 1)) begin
          pos2_r <= half_r ? pos1_r + hg : pos1_r - hg;
        end
      end
      S_RD0: begin
        w2_r <= W_ONE - quo_r - W_W'(rem_r != '0);
      end
      S_RD1: begin
        s0_r <= rv_r ? $signed(ram_rdata) : '0;
      end
      S_DIF: begin
        diff_r <= (SB + 1)'(s1) - (SB + 1)'(s0_r);
      end
      S_TAP: begin
        if (!tap_sel_r) begin
          t1_r <= tap_val;
        end else begin
          t2_r <= tap_val;
        end
      end
      S_OW2: begin
        acc_r <= (PR_W + 1)'(prod_r);
      end
      S_ACC: begin
        res_r <= sat_val;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) out_sample_r <= res_r;
      end
      default: begin
      end
    endcase
  end

  // Each accepted sample advances the write pointer by one
  a_wptr_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (wi_r == $past(wi_r) + 1'b1))
    else $error("write pointer did not advance after an input transaction");

  // Once the store has wrapped, every entry stays readable
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("store fill mark dropped");

  // A result appears only from the final step
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output became valid outside the final step");

  // Weighting starts only after both taps are done
  a_taps_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OW1) |-> tap_sel_r)
    else $error("weighting started before the second tap");

endmodule
